// ----- rtl/one_wire_master_top_defines.svh -----
// Assertion macros shared by the single-wire bus master RTL.
// Needs nothing else; expects clk and arst_n in the scope of each use.
`ifndef ONE_WIRE_MASTER_TOP_DEFINES_SVH
`define ONE_WIRE_MASTER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define OWM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("one_wire_master assertion failed");
// Next-cycle implication, checked outside reset.
`define OWM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("one_wire_master assertion failed");
`else
`define OWM_ASSERT_NOW(label, ante, cons)
`define OWM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/owm_pkg.sv -----
// Package for the single-wire bus master: word types, codes and register reset values.
// Depends on nothing; used by one_wire_master_top.
`timescale 1ns / 1ps

package owm_pkg;

	localparam int OWM_TIME_WIDTH = 10;
	localparam int OWM_ADDR_WIDTH = 5;
	localparam int OWM_DATA_WIDTH = 32;
	localparam int OWM_REG_SEL_WIDTH = OWM_ADDR_WIDTH - 2;

	// Register reset values, microseconds
	localparam int OWM_RESET_LOW_RST = 600;
	localparam int OWM_RESET_RELEASE_RST = 15;
	localparam int OWM_PRESENCE_TIMEOUT_RST = 250;
	localparam int OWM_SHORT_SLOT_RST = 2;
	localparam int OWM_LONG_SLOT_RST = 60;
	localparam int OWM_SAMPLE_DELAY_RST = 12;
	localparam int OWM_READ_RECOVERY_RST = 50;

	// Register indexes (byte address = 4 * index)
	localparam logic [OWM_REG_SEL_WIDTH-1:0] REG_RESET_LOW = 3'd0;
	localparam logic [OWM_REG_SEL_WIDTH-1:0] REG_RESET_RELEASE = 3'd1;
	localparam logic [OWM_REG_SEL_WIDTH-1:0] REG_PRESENCE_TIMEOUT = 3'd2;
	localparam logic [OWM_REG_SEL_WIDTH-1:0] REG_SHORT_SLOT = 3'd3;
	localparam logic [OWM_REG_SEL_WIDTH-1:0] REG_LONG_SLOT = 3'd4;
	localparam logic [OWM_REG_SEL_WIDTH-1:0] REG_SAMPLE_DELAY = 3'd5;
	localparam logic [OWM_REG_SEL_WIDTH-1:0] REG_READ_RECOVERY = 3'd6;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_RESET = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_PRESENCE = 2'd1,
		ST_STUCK_LOW = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_RST_LOW = 4'd1,
		PH_RST_REL = 4'd2,
		PH_RST_WAIT_LOW = 4'd3,
		PH_RST_WAIT_HIGH = 4'd4,
		PH_WR_LOW = 4'd5,
		PH_WR_HIGH = 4'd6,
		PH_RD_LOW = 4'd7,
		PH_RD_DELAY = 4'd8,
		PH_RD_SAMPLE = 4'd9,
		PH_RD_RECOVER = 4'd10
	} phase_t;

	typedef struct packed {
		cmd_t command;
		logic [7:0] tx_byte;
		logic bus_level;
	} cmd_word_t;

	typedef struct packed {
		logic bus_pull_low;
		logic busy_res;
		logic done_res;
		logic [1:0] status;
		logic [7:0] rx_byte;
	} res_word_t;

endpackage

// ----- rtl/one_wire_master_top.sv -----
// Single-wire bus master top level: tick sequencer, input and result registers, APB registers.
// Depends on owm_pkg and one_wire_master_top_defines.svh.
`timescale 1ns / 1ps

`include "one_wire_master_top_defines.svh"

// Single-wire bus master. Feed one word per microsecond tick on the cmd channel; each word
// carries a command (tick only, bus reset, byte write, byte read), the byte to send and the
// bus level sampled on that tick. Every accepted word yields exactly one result word: the
// drive for the line on that tick, busy, a done flag on the finishing tick, the last status
// (ok, no presence, stuck low) and the last byte read. Commands that arrive while busy are
// ignored. Throughput is one word per clock while the result register drains: a word waits
// in the input register, the phase sequencer updates its timer and shift state in a single
// combinational pass, and the result register holds the outcome. While a result waits on
// res_ready the input register still takes one more word, then cmd_ready drops until the
// result drains. Timing registers are written over APB at byte address 4*index (reset low
// time, release time, presence timeout, short slot, long slot, sample delay, read recovery);
// the user must write them only while no word is in flight, as the block does not enforce it.
module one_wire_master_top #(
	parameter int TIME_WIDTH = owm_pkg::OWM_TIME_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input owm_pkg::cmd_word_t cmd_word,
	output logic res_valid,
	input logic res_ready,
	output owm_pkg::res_word_t res_word,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [owm_pkg::OWM_ADDR_WIDTH-1:0] paddr,
	input logic [owm_pkg::OWM_DATA_WIDTH-1:0] pwdata,
	output logic [owm_pkg::OWM_DATA_WIDTH-1:0] prdata,
	output logic pready
);
	import owm_pkg::*;

	localparam logic [TIME_WIDTH-1:0] TIME_ONE = TIME_WIDTH'(1);

	// Timing registers
	logic [TIME_WIDTH-1:0] reset_low_q, reset_release_q, presence_timeout_q;
	logic [TIME_WIDTH-1:0] short_slot_q, long_slot_q, sample_delay_q, read_recovery_q;

	// Input stage and result register
	logic valid_s1;
	cmd_word_t item_s1;
	logic res_valid_q;
	res_word_t res_word_q;
	logic advance, fire;

	// Sequencer state
	phase_t phase_q;
	logic [TIME_WIDTH-1:0] time_left_q;
	logic [2:0] bit_count_q;
	logic [7:0] shift_byte_q;
	status_t last_status_q;
	logic [7:0] read_result_q;

	// State after a command start, then after the tick is worked
	phase_t ph_a, ph_n;
	logic [TIME_WIDTH-1:0] tl_a, tl_n;
	logic [2:0] bc_a, bc_n;
	logic [7:0] sb_a, sb_n;
	status_t st_n, fin_st;
	logic [7:0] rr_n;
	logic fin;
	logic pull;
	logic [OWM_REG_SEL_WIDTH-1:0] reg_sel;
	logic reg_write;

	function automatic logic [TIME_WIDTH-1:0] at_least_one(input logic [TIME_WIDTH-1:0] v);
		return (v == '0) ? TIME_ONE : v;
	endfunction

	// ---------------------------------------------------------------- APB registers
	assign pready = 1'b1;
	assign reg_sel = paddr[OWM_ADDR_WIDTH-1:2];
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q <= TIME_WIDTH'(OWM_RESET_LOW_RST);
			reset_release_q <= TIME_WIDTH'(OWM_RESET_RELEASE_RST);
			presence_timeout_q <= TIME_WIDTH'(OWM_PRESENCE_TIMEOUT_RST);
			short_slot_q <= TIME_WIDTH'(OWM_SHORT_SLOT_RST);
			long_slot_q <= TIME_WIDTH'(OWM_LONG_SLOT_RST);
			sample_delay_q <= TIME_WIDTH'(OWM_SAMPLE_DELAY_RST);
			read_recovery_q <= TIME_WIDTH'(OWM_READ_RECOVERY_RST);
		end else if (reg_write) begin
			unique case (reg_sel)
				REG_RESET_LOW: reset_low_q <= pwdata[TIME_WIDTH-1:0];
				REG_RESET_RELEASE: reset_release_q <= pwdata[TIME_WIDTH-1:0];
				REG_PRESENCE_TIMEOUT: presence_timeout_q <= pwdata[TIME_WIDTH-1:0];
				REG_SHORT_SLOT: short_slot_q <= pwdata[TIME_WIDTH-1:0];
				REG_LONG_SLOT: long_slot_q <= pwdata[TIME_WIDTH-1:0];
				REG_SAMPLE_DELAY: sample_delay_q <= pwdata[TIME_WIDTH-1:0];
				REG_READ_RECOVERY: read_recovery_q <= pwdata[TIME_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Read back, zero-extended
	always_comb begin
		unique case (reg_sel)
			REG_RESET_LOW: prdata = OWM_DATA_WIDTH'(reset_low_q);
			REG_RESET_RELEASE: prdata = OWM_DATA_WIDTH'(reset_release_q);
			REG_PRESENCE_TIMEOUT: prdata = OWM_DATA_WIDTH'(presence_timeout_q);
			REG_SHORT_SLOT: prdata = OWM_DATA_WIDTH'(short_slot_q);
			REG_LONG_SLOT: prdata = OWM_DATA_WIDTH'(long_slot_q);
			REG_SAMPLE_DELAY: prdata = OWM_DATA_WIDTH'(sample_delay_q);
			REG_READ_RECOVERY: prdata = OWM_DATA_WIDTH'(read_recovery_q);
			default: prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- flow control
	// Advance whenever the result register is empty or being drained; the input
	// register then refills in the same cycle, so words stream one per clock.
	assign advance = !res_valid_q || res_ready;
	assign fire = valid_s1 && advance;
	assign cmd_ready = !valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res_word = res_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	// Payload: capture on accept only
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1 <= cmd_word;
		end
	end

	// ---------------------------------------------------------------- command start
	// An idle sequencer takes a reset, write or read command and enters its first phase on this tick.
	always_comb begin
		ph_a = phase_q;
		tl_a = time_left_q;
		bc_a = bit_count_q;
		sb_a = shift_byte_q;
		if (phase_q == PH_IDLE) begin
			unique case (item_s1.command)
				CMD_RESET: begin
					ph_a = PH_RST_LOW;
					tl_a = at_least_one(reset_low_q);
				end
				CMD_WRITE: begin
					sb_a = item_s1.tx_byte;
					bc_a = '0;
					ph_a = PH_WR_LOW;
					tl_a = at_least_one(item_s1.tx_byte[0] ? short_slot_q : long_slot_q);
				end
				CMD_READ: begin
					sb_a = '0;
					bc_a = '0;
					ph_a = PH_RD_LOW;
					tl_a = at_least_one(short_slot_q);
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- next state
	// Count the phase down; at its last tick step to the next phase, skipping
	// zero-length release, sample delay and recovery phases, and close bit slots.
	always_comb begin
		ph_n = ph_a;
		tl_n = tl_a;
		bc_n = bc_a;
		sb_n = sb_a;
		st_n = last_status_q;
		rr_n = read_result_q;
		fin = 1'b0;
		fin_st = ST_OK;
		unique case (ph_a)
			PH_IDLE: ;
			PH_RST_WAIT_LOW: begin
				if (!item_s1.bus_level) begin
					ph_n = PH_RST_WAIT_HIGH;
					tl_n = at_least_one(presence_timeout_q);
				end else if (tl_a <= TIME_ONE) begin
					fin = 1'b1;
					fin_st = ST_NO_PRESENCE;
				end else begin
					tl_n = tl_a - TIME_ONE;
				end
			end
			PH_RST_WAIT_HIGH: begin
				if (item_s1.bus_level) begin
					fin = 1'b1;
					fin_st = ST_OK;
				end else if (tl_a <= TIME_ONE) begin
					fin = 1'b1;
					fin_st = ST_STUCK_LOW;
				end else begin
					tl_n = tl_a - TIME_ONE;
				end
			end
			default: begin
				// Shift the sampled bit in at the top
				if (ph_a == PH_RD_SAMPLE) begin
					sb_n = {item_s1.bus_level, sb_a[7:1]};
				end
				if (tl_a > TIME_ONE) begin
					tl_n = tl_a - TIME_ONE;
				end else begin
					unique case (ph_a)
						PH_RST_LOW: begin
							if (reset_release_q == '0) begin
								ph_n = PH_RST_WAIT_LOW;
								tl_n = at_least_one(presence_timeout_q);
							end else begin
								ph_n = PH_RST_REL;
								tl_n = reset_release_q;
							end
						end
						PH_RST_REL: begin
							ph_n = PH_RST_WAIT_LOW;
							tl_n = at_least_one(presence_timeout_q);
						end
						PH_WR_LOW: begin
							ph_n = PH_WR_HIGH;
							tl_n = at_least_one(sb_a[0] ? long_slot_q : short_slot_q);
						end
						PH_WR_HIGH: begin
							// End of a write slot: drop the bit sent
							sb_n = {1'b0, sb_a[7:1]};
							if (bc_a == 3'd7) begin
								fin = 1'b1;
							end else begin
								bc_n = bc_a + 3'd1;
								ph_n = PH_WR_LOW;
								tl_n = at_least_one(sb_a[1] ? short_slot_q : long_slot_q);
							end
						end
						PH_RD_LOW: begin
							if (sample_delay_q == '0) begin
								ph_n = PH_RD_SAMPLE;
								tl_n = TIME_ONE;
							end else begin
								ph_n = PH_RD_DELAY;
								tl_n = sample_delay_q;
							end
						end
						PH_RD_DELAY: begin
							ph_n = PH_RD_SAMPLE;
							tl_n = TIME_ONE;
						end
						PH_RD_SAMPLE, PH_RD_RECOVER: begin
							if (ph_a == PH_RD_SAMPLE && read_recovery_q != '0) begin
								ph_n = PH_RD_RECOVER;
								tl_n = read_recovery_q;
							end else if (bc_a == 3'd7) begin
								// End of the last read slot
								fin = 1'b1;
								rr_n = sb_n;
							end else begin
								bc_n = bc_a + 3'd1;
								ph_n = PH_RD_LOW;
								tl_n = at_least_one(short_slot_q);
							end
						end
						default: begin
							ph_n = PH_IDLE;
							tl_n = '0;
							bc_n = '0;
						end
					endcase
				end
			end
		endcase
		if (fin) begin
			ph_n = PH_IDLE;
			tl_n = '0;
			bc_n = '0;
			st_n = fin_st;
		end
	end

	// ---------------------------------------------------------------- outputs
	// Drive the line low through the low part of every slot and the reset pulse.
	always_comb begin
		case (ph_a) inside
			PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: pull = 1'b1;
			default: pull = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			time_left_q <= '0;
			bit_count_q <= '0;
			shift_byte_q <= '0;
			last_status_q <= ST_OK;
			read_result_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				res_valid_q <= valid_s1;
			end
			if (fire) begin
				phase_q <= ph_n;
				time_left_q <= tl_n;
				bit_count_q <= bc_n;
				shift_byte_q <= sb_n;
				last_status_q <= st_n;
				read_result_q <= rr_n;
			end
		end
	end

	// Result payload: load with each worked tick
	always_ff @(posedge clk) begin
		if (fire) begin
			res_word_q.bus_pull_low <= pull;
			res_word_q.busy_res <= (ph_n != PH_IDLE);
			res_word_q.done_res <= fin;
			res_word_q.status <= st_n;
			res_word_q.rx_byte <= rr_n;
		end
	end

	// ---------------------------------------------------------------- assertions
	`OWM_ASSERT_NOW(a_idle_clean, phase_q == PH_IDLE, time_left_q == '0 && bit_count_q == '0)
	`OWM_ASSERT_NOW(a_active_timer, phase_q != PH_IDLE, time_left_q != '0)
	`OWM_ASSERT_NOW(a_done_not_busy, res_valid_q && res_word_q.done_res, !res_word_q.busy_res)
	`OWM_ASSERT_NOW(a_pull_busy, res_valid_q && res_word_q.bus_pull_low, res_word_q.busy_res)
	`OWM_ASSERT_NEXT(a_hold_word, valid_s1 && !advance, valid_s1 && $stable(item_s1))

endmodule
